// ===== sv/ncbt_pkg.sv =====
// ---------------------------------------------------------------------------
// ncbt_pkg
// Shared types and constants for the nearest-centroid box tracker.
// ---------------------------------------------------------------------------
package ncbt_pkg;

  localparam int TRACK_MAX  = 16;
  localparam int DETECT_MAX = 16;
  localparam int TIDX_W     = $clog2(TRACK_MAX);
  localparam int TCNT_W     = $clog2(TRACK_MAX + 1);
  localparam int DIDX_W     = $clog2(DETECT_MAX);
  localparam int DCNT_W     = $clog2(DETECT_MAX + 1);

  localparam int COORD_W    = 12;
  localparam int ID_W       = 16;
  localparam int AREA_W     = 24;
  localparam int DB_W       = 13;
  localparam int SQ_W       = 28;
  localparam int ROOT_W     = 14;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [AREA_W-1:0] MIN_AREA_RST = 24'd2000;
  localparam logic [DB_W-1:0]   DEADBAND_RST = 13'd10;

  typedef enum logic [1:0] {
    KIND_DET     = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_VERDICT = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_AREA = 1'd0,
    CFG_DEADBAND = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } box_t;

  typedef struct packed {
    logic load;
    logic det;
    logic fe_start;
    logic m_start;
    logic m_take;
    logic m_apply;
    logic a_start;
    logic a_scan;
    logic a_add;
    logic fe_end;
    logic e_load;
    logic e_next;
    logic verd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic m_more;
    logic big;
    logic j_last;
    logic a_more;
    logic t_more;
    logic sq_done;
    logic out_last;
  } dp_status_t;

endpackage

// ===== sv/ncbt_isqrt.sv =====
// ---------------------------------------------------------------------------
// ncbt_isqrt
// Iterative floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module ncbt_isqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [ncbt_pkg::SQ_W-1:0]   value,
  output logic                   done,
  output logic [ncbt_pkg::ROOT_W-1:0] root
);
  import ncbt_pkg::*;

  localparam logic [SQ_W-1:0] BIT_TOP = SQ_W'(1) << (SQ_W - 2);

  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      bitv <= '0;
      done <= 1'b0;
    end else begin
      done <= (bitv == SQ_W'(1));
      if (start) begin
        rem  <= value;
        res  <= '0;
        bitv <= BIT_TOP;
      end else if (bitv != '0) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
    end
  end

endmodule

// ===== sv/ncbt_dp.sv =====
// ---------------------------------------------------------------------------
// ncbt_dp
// Datapath: track and detection tables, counters, distance and output beat.
// ---------------------------------------------------------------------------
module ncbt_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ncbt_pkg::ctrl_cmd_t           cmd,
  output ncbt_pkg::dp_status_t          status,
  input  logic [ncbt_pkg::IN_DATA_W-1:0] in_data,
  input  logic                          cfg_we,
  input  logic [ncbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ncbt_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [ncbt_pkg::OUT_DATA_W-1:0] out_data,
  output logic                          out_last
);
  import ncbt_pkg::*;

  logic [AREA_W-1:0] min_area;
  logic [DB_W-1:0]   deadband;

  logic [COORD_W-1:0] lx, ty, rx, by;
  logic               ok;

  box_t              tbox [TRACK_MAX];
  logic [ID_W-1:0]   tid  [TRACK_MAX];
  box_t              dbox [DETECT_MAX];

  logic [TCNT_W-1:0] tc, otc, mi, ta, ei, vi;
  logic [DCNT_W-1:0] dc, dj, ai;
  logic [DIDX_W-1:0] best;
  logic [ROOT_W-1:0] bestd;
  logic [ID_W-1:0]   next_id;
  logic              big, touched, pend, fovf;

  logic [TCNT_W-1:0] tsel;
  logic [DCNT_W-1:0] dsel;
  box_t              tb, db, nb;
  logic [COORD_W-1:0] nw, nh;
  logic [AREA_W-1:0] area;
  logic              det_ok;

  logic [COORD_W:0]    ctx, cty, cdx, cdy;
  logic signed [COORD_W+1:0] dx, dy;
  logic signed [SQ_W-1:0]    sqx, sqy;
  logic [SQ_W-1:0]     sq;
  logic                sq_done;
  logic [ROOT_W-1:0]   root;

  logic [COORD_W:0]    t_xe, t_ye, d_xe, d_ye;
  logic                touch;

  always_comb begin
    if (cmd.a_scan)      tsel = ta;
    else if (cmd.e_load) tsel = ei;
    else if (cmd.verd)   tsel = vi;
    else                 tsel = mi;
    if (cmd.m_start)      dsel = dj;
    else if (cmd.m_apply) dsel = DCNT_W'(best);
    else                  dsel = ai;
  end

  assign tb = tbox[tsel[TIDX_W-1:0]];
  assign db = dbox[dsel[DIDX_W-1:0]];

  assign nw     = rx - lx;
  assign nh     = by - ty;
  assign area   = nw * nh;
  assign det_ok = (rx >= lx) && (by >= ty) && (area > min_area) && ok;
  assign nb     = '{x: lx, y: ty, w: nw, h: nh};

  assign ctx = {1'b0, tb.x} + {2'b0, tb.w[COORD_W-1:1]};
  assign cty = {1'b0, tb.y} + {2'b0, tb.h[COORD_W-1:1]};
  assign cdx = {1'b0, db.x} + {2'b0, db.w[COORD_W-1:1]};
  assign cdy = {1'b0, db.y} + {2'b0, db.h[COORD_W-1:1]};
  assign dx  = $signed({1'b0, cdx}) - $signed({1'b0, ctx});
  assign dy  = $signed({1'b0, cdy}) - $signed({1'b0, cty});
  assign sqx = SQ_W'(dx * dx);
  assign sqy = SQ_W'(dy * dy);
  assign sq  = $unsigned(sqx) + $unsigned(sqy);

  assign t_xe  = {1'b0, tb.x} + {1'b0, tb.w};
  assign t_ye  = {1'b0, tb.y} + {1'b0, tb.h};
  assign d_xe  = {1'b0, db.x} + {1'b0, db.w};
  assign d_ye  = {1'b0, db.y} + {1'b0, db.h};
  assign touch = ((db.x >= tb.x && {1'b0, db.x} <= t_xe) ||
                  (tb.x >= db.x && {1'b0, tb.x} <= d_xe)) &&
                 ((db.y >= tb.y && {1'b0, db.y} <= t_ye) ||
                  (tb.y >= db.y && {1'b0, tb.y} <= d_ye));

  ncbt_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.m_start),
    .value (sq),
    .done  (sq_done),
    .root  (root)
  );

  assign status.m_more   = (mi < otc) && (dc != '0);
  assign status.big      = big;
  assign status.j_last   = (dj + DCNT_W'(1)) == dc;
  assign status.a_more   = ai < dc;
  assign status.t_more   = ta < tc;
  assign status.sq_done  = sq_done;
  assign status.out_last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_area <= MIN_AREA_RST;
      deadband <= DEADBAND_RST;
      tc       <= '0;
      dc       <= '0;
      next_id  <= '0;
      vi       <= '0;
      pend     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MIN_AREA: min_area <= cfg_data;
          CFG_DEADBAND: deadband <= cfg_data[DB_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        lx <= in_data[11:0];
        ty <= in_data[23:12];
        rx <= in_data[35:24];
        by <= in_data[47:36];
        ok <= in_data[48];
      end
      if (cmd.det && det_ok) begin
        if (dc < DCNT_W'(DETECT_MAX)) begin
          dbox[dc[DIDX_W-1:0]] <= nb;
          dc <= dc + DCNT_W'(1);
        end else begin
          pend <= 1'b1;
        end
      end
      if (cmd.fe_start) begin
        mi  <= '0;
        dj  <= '0;
        otc <= tc;
        big <= dc > DCNT_W'(tc);
      end
      if (cmd.m_take) begin
        if (dj == '0 || root < bestd) begin
          bestd <= root;
          best  <= dj[DIDX_W-1:0];
        end
        dj <= dj + DCNT_W'(1);
      end
      if (cmd.m_apply) begin
        if ({1'b0, bestd} > {2'b0, deadband}) tbox[mi[TIDX_W-1:0]] <= db;
        for (int k = 0; k < DETECT_MAX - 1; k++) begin
          if (k >= int'(best)) dbox[k] <= dbox[k+1];
        end
        dc <= dc - DCNT_W'(1);
        mi <= mi + TCNT_W'(1);
        dj <= '0;
      end
      if (cmd.a_start) begin
        ai      <= '0;
        ta      <= '0;
        touched <= 1'b0;
      end
      if (cmd.a_scan) begin
        if (touch) touched <= 1'b1;
        ta <= ta + TCNT_W'(1);
      end
      if (cmd.a_add) begin
        if (!touched) begin
          if (tc < TCNT_W'(TRACK_MAX)) begin
            tbox[tc[TIDX_W-1:0]] <= db;
            tid[tc[TIDX_W-1:0]]  <= next_id;
            tc      <= tc + TCNT_W'(1);
            next_id <= next_id + ID_W'(1);
          end else begin
            pend <= 1'b1;
          end
        end
        ai      <= ai + DCNT_W'(1);
        ta      <= '0;
        touched <= 1'b0;
      end
      if (cmd.fe_end) begin
        dc   <= '0;
        vi   <= '0;
        ei   <= '0;
        fovf <= pend;
        pend <= 1'b0;
      end
      if (cmd.e_next) ei <= ei + TCNT_W'(1);
      if (cmd.e_load) begin
        if (tc == '0) begin
          out_data <= {1'b0, fovf, 1'b0, 1'b0, ID_W'(0), 48'd0, 4'd0};
          out_last <= 1'b1;
        end else begin
          out_data <= {1'b0, fovf, 1'b1, 1'b1, tid[ei[TIDX_W-1:0]],
                       tb.h, tb.w, tb.y, tb.x, 4'(ei)};
          out_last <= (ei + TCNT_W'(1)) == tc;
        end
      end
      if (cmd.verd) begin
        out_last <= 1'b1;
        if (vi >= tc) begin
          out_data <= '0;
        end else begin
          out_data <= {1'b0, 1'b0, 1'b1, ok, tid[vi[TIDX_W-1:0]],
                       tb.h, tb.w, tb.y, tb.x, 4'(vi)};
          if (ok) begin
            vi <= vi + TCNT_W'(1);
          end else begin
            for (int k = 0; k < TRACK_MAX - 1; k++) begin
              if (k >= int'(vi)) begin
                tbox[k] <= tbox[k+1];
                tid[k]  <= tid[k+1];
              end
            end
            tc <= tc - TCNT_W'(1);
          end
        end
      end
    end
  end

endmodule

// ===== sv/ncbt_ctrl.sv =====
// ---------------------------------------------------------------------------
// ncbt_ctrl
// Controller: sequences detection, frame-end matching, append, verdict and output.
// ---------------------------------------------------------------------------
module ncbt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_kind,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ncbt_pkg::ctrl_cmd_t  cmd,
  input  ncbt_pkg::dp_status_t status
);
  import ncbt_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DET      = 15'b000000000000010,
    S_FE_START = 15'b000000000000100,
    S_M_CHECK  = 15'b000000000001000,
    S_M_DIST   = 15'b000000000010000,
    S_M_WAIT   = 15'b000000000100000,
    S_M_APPLY  = 15'b000000001000000,
    S_A_START  = 15'b000000010000000,
    S_A_CHECK  = 15'b000000100000000,
    S_A_SCAN   = 15'b000001000000000,
    S_A_ADD    = 15'b000010000000000,
    S_FE_END   = 15'b000100000000000,
    S_E_LOAD   = 15'b001000000000000,
    S_VERD     = 15'b010000000000000,
    S_OUT_WAIT = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT_WAIT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (kind_t'(in_kind))
            KIND_DET:     state_next = S_DET;
            KIND_FRAME:   state_next = S_FE_START;
            KIND_VERDICT: state_next = S_VERD;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_DET: begin
        cmd.det    = 1'b1;
        state_next = S_IDLE;
      end
      S_FE_START: begin
        cmd.fe_start = 1'b1;
        state_next   = S_M_CHECK;
      end
      S_M_CHECK: begin
        if (status.m_more)  state_next = S_M_DIST;
        else if (status.big) state_next = S_A_START;
        else                state_next = S_FE_END;
      end
      S_M_DIST: begin
        cmd.m_start = 1'b1;
        state_next  = S_M_WAIT;
      end
      S_M_WAIT: begin
        if (status.sq_done) begin
          cmd.m_take = 1'b1;
          state_next = status.j_last ? S_M_APPLY : S_M_DIST;
        end
      end
      S_M_APPLY: begin
        cmd.m_apply = 1'b1;
        state_next  = S_M_CHECK;
      end
      S_A_START: begin
        cmd.a_start = 1'b1;
        state_next  = S_A_CHECK;
      end
      S_A_CHECK: begin
        state_next = status.a_more ? S_A_SCAN : S_FE_END;
      end
      S_A_SCAN: begin
        if (status.t_more) cmd.a_scan = 1'b1;
        else               state_next = S_A_ADD;
      end
      S_A_ADD: begin
        cmd.a_add  = 1'b1;
        state_next = S_A_CHECK;
      end
      S_FE_END: begin
        cmd.fe_end = 1'b1;
        state_next = S_E_LOAD;
      end
      S_E_LOAD: begin
        cmd.e_load = 1'b1;
        state_next = S_OUT_WAIT;
      end
      S_VERD: begin
        cmd.verd   = 1'b1;
        state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready) begin
          if (status.out_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.e_next = 1'b1;
            state_next = S_E_LOAD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== sv/nearest_centroid_box_tracker.sv =====
// ---------------------------------------------------------------------------
// nearest_centroid_box_tracker
// Frame-based nearest-centroid tracker over up to 16 boxes.
//
//  channel  dir  beat contents
//  s_*      in   detection / frame end / verdict item
//  m_*      out  one track table entry per beat, tlast on the final one
//  cfg_*    in   min_area (0), move_deadband (1)
//
// A verdict item also waits for its output beat to be accepted.
// Frame end: each track is matched against every remaining detection
// in the shared square-root unit (launch, 14 steps, take); the append pass,
// run only when detections outnumbered tracks, scans every track for each
// leftover; then the table is emitted one entry per beat.
// Reset is synchronous; output stalls hold the controller in place.
// ---------------------------------------------------------------------------
module nearest_centroid_box_tracker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // left_x, top_y, right_x, bottom_y, region_ok, zero pad
  input  logic [ncbt_pkg::IN_DATA_W-1:0] s_tdata,
  // kind
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // slot, box_x, box_y, box_w, box_h, object_id, kept, entry_valid,
  // overflow, zero pad
  output logic [ncbt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [ncbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ncbt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ncbt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ncbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_kind   (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

  ncbt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-centroid box tracker: detection, frame
// end and verdict beats go in, a local model predicts every table beat and a
// monitor compares each output beat field by field.
// ---------------------------------------------------------------------------
module tb;
  import ncbt_pkg::*;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } rect_t;

  typedef struct {
    logic [3:0]  slot;
    logic [11:0] bx;
    logic [11:0] by;
    logic [11:0] bw;
    logic [11:0] bh;
    logic [15:0] oid;
    logic        kept;
    logic        valid;
    logic        ovf;
    logic        last;
  } entry_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = 2'd0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nearest_centroid_box_tracker uut (.*);

  always #5 clk = ~clk;

  // tracker state mirror
  rect_t  trk[TRACK_MAX];
  int     trk_id[TRACK_MAX];
  rect_t  det[DETECT_MAX];
  int     n_trk = 0;
  int     n_det = 0;
  int     id_next = 0;
  int     vidx = 0;
  bit     ovf_pend = 0;
  int     min_area_r = 2000;
  int     deadband_r = 10;

  entry_t table_q[$];
  int     errors = 0;
  int     n_items = 0;
  int     n_beats = 0;
  int     n_frames = 0;
  bit     tx_idle = 1;
  bit     rx_idle = 1;
  bit     hold_go = 0;
  int     hold_cnt = 0;

  function automatic int root_floor(int v);
    int r;
    int t;
    r = 0;
    for (int b = 13; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic int centre_gap(rect_t a, rect_t b);
    int dx;
    int dy;
    dx = (b.x + b.w / 2) - (a.x + a.w / 2);
    dy = (b.y + b.h / 2) - (a.y + a.h / 2);
    return root_floor(dx * dx + dy * dy);
  endfunction

  function automatic bit span_hit(int v, int lo, int hi);
    return v >= lo && v <= hi;
  endfunction

  function automatic bit overlaps_track(rect_t r);
    bit xo;
    bit yo;
    for (int i = 0; i < n_trk; i++) begin
      xo = span_hit(r.x, trk[i].x, trk[i].x + trk[i].w) ||
           span_hit(trk[i].x, r.x, r.x + r.w);
      yo = span_hit(r.y, trk[i].y, trk[i].y + trk[i].h) ||
           span_hit(trk[i].y, r.y, r.y + r.h);
      if (xo && yo) return 1;
    end
    return 0;
  endfunction

  function automatic void match_nearest(int i);
    int best;
    int d;
    int d2;
    best = 0;
    d = centre_gap(trk[i], det[0]);
    for (int j = 1; j < n_det; j++) begin
      d2 = centre_gap(trk[i], det[j]);
      if (d2 < d) begin
        d = d2;
        best = j;
      end
    end
    if (d > deadband_r) trk[i] = det[best];
    for (int j = best; j + 1 < n_det; j++) det[j] = det[j + 1];
    n_det--;
  endfunction

  function automatic void push_entry(int slot, rect_t b, int oid, bit kept, bit valid,
                                     bit ovf, bit last);
    entry_t e;
    e.slot = slot[3:0];
    e.bx = b.x[11:0];
    e.by = b.y[11:0];
    e.bw = b.w[11:0];
    e.bh = b.h[11:0];
    e.oid = oid[15:0];
    e.kept = kept;
    e.valid = valid;
    e.ovf = ovf;
    e.last = last;
    table_q.insert(table_q.size(), e);
  endfunction

  function automatic void predict_table(kind_t kind, int lx, int ty, int rx, int by, bit ok);
    rect_t b;
    rect_t z;
    int t;
    bit o;
    z = '{0, 0, 0, 0};
    case (kind)
      KIND_DET: begin
        if (rx >= lx && by >= ty) begin
          b = '{lx, ty, rx - lx, by - ty};
          if (b.w * b.h > min_area_r && ok) begin
            if (n_det < DETECT_MAX) begin
              det[n_det] = b;
              n_det = n_det + 1;
            end else begin
              ovf_pend = 1;
            end
          end
        end
      end
      KIND_FRAME: begin
        n_frames++;
        if (n_det > n_trk) begin
          t = n_trk;
          for (int i = 0; i < t; i++) match_nearest(i);
          for (int i = 0; i < n_det; i++) begin
            if (!overlaps_track(det[i])) begin
              if (n_trk < TRACK_MAX) begin
                trk[n_trk] = det[i];
                trk_id[n_trk] = id_next;
                n_trk++;
                id_next = (id_next + 1) & 16'hFFFF;
              end else begin
                ovf_pend = 1;
              end
            end
          end
        end else begin
          for (int i = 0; i < n_trk && n_det > 0; i++) match_nearest(i);
        end
        n_det = 0;
        vidx = 0;
        o = ovf_pend;
        ovf_pend = 0;
        if (n_trk == 0) push_entry(0, z, 0, 0, 0, o, 1);
        for (int i = 0; i < n_trk; i++)
          push_entry(i, trk[i], trk_id[i], 1, 1, o, i + 1 == n_trk);
      end
      KIND_VERDICT: begin
        if (vidx >= n_trk) begin
          push_entry(0, z, 0, 0, 0, 0, 1);
        end else if (ok) begin
          push_entry(vidx, trk[vidx], trk_id[vidx], 1, 1, 0, 1);
          vidx++;
        end else begin
          push_entry(vidx, trk[vidx], trk_id[vidx], 0, 1, 0, 1);
          for (int i = vidx; i + 1 < n_trk; i++) begin
            trk[i] = trk[i + 1];
            trk_id[i] = trk_id[i + 1];
          end
          n_trk--;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(kind_t kind, int lx, int ty, int rx, int by, bit ok);
    if (tx_idle && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {7'd0, ok, by[11:0], rx[11:0], ty[11:0], lx[11:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_table(kind, lx, ty, rx, by, ok);
    n_items++;
  endtask

  task automatic send_det(int lx, int ty, int w, int h, bit ok);
    int rx;
    int by;
    rx = lx + w > 4095 ? 4095 : lx + w;
    by = ty + h > 4095 ? 4095 : ty + h;
    send_item(KIND_DET, lx, ty, rx, by, ok);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (table_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_AREA) min_area_r = val & 24'hFFFFFF;
    else deadband_r = val & 13'h1FFF;
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_cnt = 600;
      hold_go = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(rx_idle && $urandom_range(99) < 22);
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    entry_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_beats++;
      if (table_q.size() == 0) begin
        $error("unexpected output beat %h", m_tdata);
        errors++;
      end else begin
        e = table_q.pop_front();
        check_field("slot", e.slot, m_tdata[3:0]);
        check_field("box_x", e.bx, m_tdata[15:4]);
        check_field("box_y", e.by, m_tdata[27:16]);
        check_field("box_w", e.bw, m_tdata[39:28]);
        check_field("box_h", e.bh, m_tdata[51:40]);
        check_field("object_id", e.oid, m_tdata[67:52]);
        check_field("kept", e.kept, m_tdata[68]);
        check_field("entry_valid", e.valid, m_tdata[69]);
        check_field("overflow", e.ovf, m_tdata[70]);
        check_field("last", e.last, m_tlast);
      end
    end
  end

  task automatic test_edges;
    write_reg(CFG_MIN_AREA, 2000);
    write_reg(CFG_DEADBAND, 0);
    send_item(KIND_FRAME, 0, 0, 0, 0, 0);
    send_item(KIND_VERDICT, 0, 0, 0, 0, 1);
    send_item(KIND_NONE, 4095, 4095, 4095, 4095, 1);
    send_item(KIND_DET, 100, 100, 50, 200, 1);
    send_item(KIND_DET, 100, 200, 200, 100, 1);
    send_item(KIND_DET, 0, 0, 40, 50, 1);
    send_item(KIND_DET, 0, 0, 4095, 4095, 0);
    send_item(KIND_DET, 0, 0, 4095, 4095, 1);
    send_item(KIND_DET, 4000, 4000, 4095, 4095, 1);
    send_item(KIND_DET, 3000, 100, 3100, 200, 1);
    send_item(KIND_FRAME, 0, 0, 0, 0, 0);
    send_item(KIND_DET, 3005, 102, 3105, 202, 1);
    send_item(KIND_DET, 3900, 3900, 4095, 4095, 1);
    send_item(KIND_FRAME, 0, 0, 0, 0, 0);
    send_item(KIND_FRAME, 0, 0, 0, 0, 0);
    send_item(KIND_VERDICT, 0, 0, 0, 0, 1);
    send_item(KIND_VERDICT, 0, 0, 0, 0, 0);
    send_item(KIND_VERDICT, 0, 0, 0, 0, 1);
    send_item(KIND_VERDICT, 0, 0, 0, 0, 0);
    send_item(KIND_VERDICT, 0, 0, 0, 0, 1);
  endtask

  task automatic test_table_limits;
    write_reg(CFG_MIN_AREA, 0);
    write_reg(CFG_DEADBAND, 8191);
    for (int i = 0; i < 17; i++) send_det(i * 200, i * 200, 10, 10, 1);
    send_item(KIND_FRAME, 0, 0, 0, 0, 0);
    for (int i = 0; i < 16; i++) send_det(i * 200 + 50, i * 200 + 50, 10, 10, 1);
    send_item(KIND_FRAME, 0, 0, 0, 0, 0);
    write_reg(CFG_MIN_AREA, 16777215);
    send_item(KIND_DET, 0, 0, 4095, 4095, 1);
    for (int i = 0; i < 17; i++) send_item(KIND_VERDICT, 0, 0, 0, 0, 0);
    send_item(KIND_FRAME, 0, 0, 0, 0, 0);
  endtask

  task automatic test_backpressure;
    write_reg(CFG_MIN_AREA, 100);
    write_reg(CFG_DEADBAND, 5);
    hold_go = 1;
    for (int f = 0; f < 4; f++) begin
      for (int i = 0; i < 4; i++)
        send_det($urandom_range(4000), $urandom_range(4000), 30, 30, 1);
      send_item(KIND_FRAME, 0, 0, 0, 0, 0);
      for (int i = 0; i < 3; i++) send_item(KIND_VERDICT, 0, 0, 0, 0, 1);
    end
  endtask

  task automatic rand_det;
    int lx;
    int ty;
    int w;
    int h;
    int k;
    if (n_trk > 0 && $urandom_range(1)) begin
      k = $urandom_range(n_trk - 1);
      lx = trk[k].x + $urandom_range(40) - 20;
      ty = trk[k].y + $urandom_range(40) - 20;
      w = trk[k].w + $urandom_range(10);
      h = trk[k].h + $urandom_range(10);
      lx = lx < 0 ? 0 : lx > 4095 ? 4095 : lx;
      ty = ty < 0 ? 0 : ty > 4095 ? 4095 : ty;
    end else begin
      lx = $urandom_range(4095);
      ty = $urandom_range(4095);
      w = $urandom_range(99) < 5 ? $urandom_range(4095) : $urandom_range(150);
      h = $urandom_range(99) < 5 ? $urandom_range(4095) : $urandom_range(150);
    end
    if ($urandom_range(99) < 5) send_item(KIND_DET, lx, ty, $urandom_range(4095),
                                          $urandom_range(4095), 1);
    else send_det(lx, ty, w, h, $urandom_range(99) < 90);
  endtask

  task automatic test_random;
    int nd;
    int nv;
    int goal;
    goal = n_items + 300;
    while (n_items < goal) begin
      if ($urandom_range(99) < 10) begin
        write_reg(CFG_MIN_AREA, $urandom_range(99) < 20 ? $urandom : $urandom_range(3000));
        write_reg(CFG_DEADBAND, $urandom_range(99) < 20 ? $urandom : $urandom_range(30));
      end
      tx_idle = !(n_items > goal - 150 && n_items < goal - 80);
      rx_idle = tx_idle;
      nd = $urandom_range(99) < 4 ? 17 : $urandom_range(6);
      for (int i = 0; i < nd; i++) rand_det();
      if ($urandom_range(99) < 5)
        send_item(KIND_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
      send_item(KIND_FRAME, $urandom, $urandom, $urandom, $urandom, $urandom);
      nv = $urandom_range(n_trk + 1);
      for (int i = 0; i < nv; i++)
        send_item(KIND_VERDICT, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(99) < 80);
    end
    tx_idle = 1;
    rx_idle = 1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_table_limits();
    test_backpressure();
    test_random();
    drain();
    $display("Covered %0d input beats over %0d frames, %0d table beats checked.",
             n_items, n_frames, n_beats);
    $display("Register settings, full tables, stalls and hold-off were exercised.");
    if (errors == 0 && table_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ncbt_pkg.sv
sv/ncbt_isqrt.sv
sv/ncbt_dp.sv
sv/ncbt_ctrl.sv
sv/nearest_centroid_box_tracker.sv
tb/tb.sv
